>>> hdl/pfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, register indexes and channel expansion tables for the
// pixel format converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

  typedef enum logic [1:0] {
    FMT_RGB1555  = 2'd0,
    FMT_RGB565   = 2'd1,
    FMT_XRGB8888 = 2'd2
  } fmt_t;

  localparam logic REG_SOURCE_FORMAT = 1'b0;
  localparam logic REG_NTSC_PACK     = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic       known;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam logic [7:0] EXPAND5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
    8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
    8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
    8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
  };

  localparam logic [7:0] EXPAND6 [64] = '{
    8'd0,   8'd4,   8'd8,   8'd12,  8'd16,  8'd20,  8'd24,  8'd28,
    8'd32,  8'd36,  8'd40,  8'd45,  8'd49,  8'd53,  8'd57,  8'd61,
    8'd65,  8'd69,  8'd73,  8'd77,  8'd81,  8'd85,  8'd89,  8'd93,
    8'd97,  8'd101, 8'd105, 8'd109, 8'd113, 8'd117, 8'd121, 8'd125,
    8'd130, 8'd134, 8'd138, 8'd142, 8'd146, 8'd150, 8'd154, 8'd158,
    8'd162, 8'd166, 8'd170, 8'd174, 8'd178, 8'd182, 8'd186, 8'd190,
    8'd194, 8'd198, 8'd202, 8'd206, 8'd210, 8'd215, 8'd219, 8'd223,
    8'd227, 8'd231, 8'd235, 8'd239, 8'd243, 8'd247, 8'd251, 8'd255
  };

endpackage
`default_nettype wire

>>> hdl/pfc_unpack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_unpack
// Splits a source pixel into 8-bit red, green and blue channels according
// to the source format.
// ----------------------------------------------------------------------------
module pfc_unpack
  import pfc_pkg::*;
(
  input  wire logic [23:0] pixel,
  input  wire fmt_t        fmt,
  output rgb_t             ch
);

  always_comb begin
    ch = '0;
    unique case (fmt)
      FMT_RGB1555: begin
        ch.known = 1'b1;
        ch.r     = {pixel[14:10], 3'b000};
        ch.g     = {pixel[9:5], 3'b000};
        ch.b     = {pixel[4:0], 3'b000};
      end
      FMT_RGB565: begin
        ch.known = 1'b1;
        ch.r     = EXPAND5[pixel[15:11]];
        ch.g     = EXPAND6[pixel[10:5]];
        ch.b     = EXPAND5[pixel[4:0]];
      end
      FMT_XRGB8888: begin
        ch.known = 1'b1;
        ch.r     = pixel[23:16];
        ch.g     = pixel[15:8];
        ch.b     = pixel[7:0];
      end
      default: begin
        ch = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/pixel_format_to_rgba_converter_core.sv
`default_nettype none
// Throughput: one beat per cycle; a stall backs up through the three stages.
// Stages: input register, channel expansion, output packing register.
// Reset: rst clears all stage valid bits and both configuration registers.
// ----------------------------------------------------------------------------
// pixel_format_to_rgba_converter_core
// Converts 0RGB1555, RGB565 or XRGB8888 pixels to RGBA8888 or RGB565.
// ----------------------------------------------------------------------------
module pixel_format_to_rgba_converter_core
  import pfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] pixel_in,
  input  wire logic        line_end,
  input  wire logic        frame_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      pixel_out,
  output logic             line_end_out,
  output logic             frame_end_out
);

  fmt_t        source_format;
  logic        ntsc_pack;

  logic        valid1;
  logic [23:0] pixel1;
  fmt_t        fmt1;
  logic        pack1;
  logic        le1;
  logic        fe1;

  logic        valid2;
  rgb_t        ch2;
  logic        pack2;
  logic        le2;
  logic        fe2;

  logic        valid3;
  logic [31:0] pixel3;
  logic        le3;
  logic        fe3;

  logic        rdy1;
  logic        rdy2;
  logic        rdy3;
  rgb_t        ch1;
  logic [31:0] pixel3_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_RGB1555;
      ntsc_pack     <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_FORMAT: source_format <= fmt_t'(cfg_data);
        REG_NTSC_PACK:     ntsc_pack     <= cfg_data[0];
        default:           ntsc_pack     <= ntsc_pack;
      endcase
    end
  end

  assign rdy3     = !valid3 || out_ready;
  assign rdy2     = !valid2 || rdy3;
  assign rdy1     = !valid1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (rdy1) begin
      valid1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      pixel1 <= pixel_in[23:0];
      fmt1   <= source_format;
      pack1  <= ntsc_pack;
      le1    <= line_end;
      fe1    <= frame_end;
    end
  end

  pfc_unpack u_unpack (
    .pixel (pixel1),
    .fmt   (fmt1),
    .ch    (ch1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (rdy2) begin
      valid2 <= valid1;
    end
    if (rdy2 && valid1) begin
      ch2   <= ch1;
      pack2 <= pack1;
      le2   <= le1;
      fe2   <= fe1;
    end
  end

  always_comb begin
    if (!ch2.known) begin
      pixel3_next = '0;
    end else if (pack2) begin
      pixel3_next = {16'h0000, ch2.r[7:3], ch2.g[7:2], ch2.b[7:3]};
    end else begin
      pixel3_next = {ALPHA_OPAQUE, ch2.b, ch2.g, ch2.r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (rdy3) begin
      valid3 <= valid2;
    end
    if (rdy3 && valid2) begin
      pixel3 <= pixel3_next;
      le3    <= le2;
      fe3    <= fe2;
    end
  end

  assign out_valid     = valid3;
  assign pixel_out     = pixel3;
  assign line_end_out  = le3;
  assign frame_end_out = fe3;

  a_ready_only_when_full : assert property (
    @(posedge clk) disable iff (rst)
    !in_ready |-> (valid1 && valid2 && valid3)
  ) else $error("input stalled while the pipeline has a free stage");

  a_stage2_advance : assert property (
    @(posedge clk) disable iff (rst)
    (valid1 && rdy2) |=> valid2
  ) else $error("beat lost between stage 1 and stage 2");

  a_full_holds : assert property (
    @(posedge clk) disable iff (rst)
    (valid1 && valid2 && valid3 && !out_ready) |=> (valid1 && valid2 && valid3)
  ) else $error("beat dropped while the output was stalled");

  a_alpha_opaque : assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && (pixel_out[31:16] != 16'h0000)) |-> (pixel_out[31:24] == ALPHA_OPAQUE)
  ) else $error("RGBA result without opaque alpha");

endmodule
`default_nettype wire
